[hdl/cch_pkg.sv]
`default_nettype none
package cch_pkg;
    localparam int MASS_W  = 24;
    localparam int FIELD_W = 16;
    localparam int COUNT_W = 32;
    localparam int ADDR_W  = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TYPE_SEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASS_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASS_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIGHT_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIGHT_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOSE_LOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOOSE_HIGH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FSIG_MIN  = 3'd7;

    localparam logic [2:0] H_DAU     = 3'd0;
    localparam logic [2:0] H_SIG     = 3'd1;
    localparam logic [2:0] H_BKG     = 3'd2;
    localparam logic [2:0] H_SIGDIFF = 3'd3;
    localparam logic [2:0] H_BKGDIFF = 3'd4;
    localparam int HIST_COUNT = 5;

    localparam logic [MASS_W-1:0] DIFF_LOW  = 24'd141558;
    localparam logic [MASS_W-1:0] DIFF_HIGH = 24'd161481;
    localparam logic signed [FIELD_W-1:0] ETA_LIMIT = 16'sd8192;
    localparam logic [2:0] TYPE_SIGNAL_ALL = 3'd2;

    typedef logic [FIELD_W-1:0] pt_edge_t [0:8];
    localparam pt_edge_t PT_EDGES = '{16'd0, 16'd1024, 16'd1280, 16'd2048,
        16'd3072, 16'd4096, 16'd6400, 16'd10240, 16'd51200};

    typedef struct packed {
        logic                start;
        logic [MASS_W-1:0]   x;
        logic [MASS_W-1:0]   lo;
        logic [MASS_W-1:0]   hi;
    } bin_req_t;
endpackage
`default_nettype wire

[hdl/cch_if.sv]
`default_nettype none
interface cch_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  cand_type;
    logic [23:0] mass;
    logic [23:0] dau_mass;
    logic [15:0] pt;
    logic signed [15:0] eta;
    logic [15:0] flight_sig;
    logic [15:0] pointing_angle;
    logic [15:0] vertex_prob;
    logic [15:0] dca;
    logic [15:0] chi2;
    logic [14:0] read_address;
    modport source (output valid, op, cand_type, mass, dau_mass, pt, eta, flight_sig,
        pointing_angle, vertex_prob, dca, chi2, read_address, input ready);
    modport sink (input valid, op, cand_type, mass, dau_mass, pt, eta, flight_sig,
        pointing_angle, vertex_prob, dca, chi2, read_address, output ready);
endinterface

interface cch_out_if;
    logic        valid;
    logic        ready;
    logic        passed;
    logic [2:0]  pt_bin;
    logic [31:0] bin_count;
    modport source (output valid, passed, pt_bin, bin_count, input ready);
    modport sink (input valid, passed, pt_bin, bin_count, output ready);
endinterface
`default_nettype wire

[hdl/candidate_cut_histogrammer_top.sv]
// Candidate cut histogrammer.
// Input channel in: one word is a candidate (op 0) or a bin read (op 1).
// Output channel out: one result word per input word (passed, pt_bin,
// bin_count). Config: cfg_we/cfg_index/cfg_data, write only while idle.
// Candidates are cut, binned in pt and, when passing, fill up to four bins of
// five 350-bin histograms held in one single-port-write RAM of 32-bit counts.
// Each fill computes its bin with a shared bit-serial divider (no division
// when the value is out of range), then a read-modify-write of the RAM.
// One word is in flight at a time; in is not ready until the result has been
// taken, and the next word is accepted the cycle after that.
// After reset a clearing pass writes zero to every count, one per cycle;
// in.ready stays low meanwhile.
// A stalled out holds its word; the block waits with it.
`default_nettype none
module candidate_cut_histogrammer_top
    import cch_pkg::*;
#(
    parameter int NUM_PT_BINS   = 8,
    parameter int NUM_MASS_BINS = 350,
    parameter int ANGLE_MAX     = 8192,
    parameter int PROB_MIN      = 3277,
    parameter int DCA_MAX       = 64,
    parameter int CHI2_MAX      = 512
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cch_in_if.sink                     in,
    cch_out_if.source                  out,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int BPH    = NUM_MASS_BINS + 2;
    localparam int DEPTH  = HIST_COUNT * NUM_PT_BINS * BPH;
    localparam int AW     = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(BPH);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_NEXT  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_RDW   = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_RREAD = 4'd7;
    localparam logic [3:0] S_RWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0] type_sel_reg;
    logic [MASS_W-1:0] mass_low_reg, mass_high_reg, tight_low_reg, tight_high_reg;
    logic [MASS_W-1:0] loose_low_reg, loose_high_reg;
    logic [FIELD_W-1:0] fsig_min_reg;

    logic [MASS_W-1:0] mass_reg, mdau_reg;
    logic [2:0] ptb_reg, ptb_next;
    logic [7:0] fill_reg, fill_next;
    logic [2:0] fidx_reg, fidx_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic rvalid_reg, rvalid_next;
    logic passed_reg, passed_next;
    logic [2:0] optb_reg, optb_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic ovalid_reg, ovalid_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [COUNT_W-1:0] ram_wdata, ram_rdata;
    bin_req_t breq;
    logic bdone;
    logic [BIN_W-1:0] bbin;

    logic [2:0] ptb_calc;
    logic pass_calc, loose_in, tight_in, tight_out;
    logic [2:0] fill_hist;
    logic [MASS_W-1:0] diff;
    logic [2:0] rh, rp;
    logic [8:0] rb;

    cch_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata));

    cch_binner #(.NUM_MASS_BINS(NUM_MASS_BINS)) u_bin (
        .clk(clk), .rst_n(rst_n), .req(breq), .done(bdone), .bin(bbin));

    always_comb
    begin
        ptb_calc = 3'd7;
        for (int i = 7; i >= 0; i--)
        begin
            if (in.pt >= PT_EDGES[i] && in.pt < PT_EDGES[i+1])
            begin
                ptb_calc = 3'(i);
            end
        end
        if (int'(ptb_calc) > NUM_PT_BINS - 1)
        begin
            ptb_calc = 3'(NUM_PT_BINS - 1);
        end
    end

    assign pass_calc = in.cand_type == type_sel_reg
        && in.eta <= ETA_LIMIT && in.eta >= -ETA_LIMIT
        && in.mass > mass_low_reg && in.mass < mass_high_reg
        && in.flight_sig > fsig_min_reg
        && 32'(in.pointing_angle) < 32'(ANGLE_MAX)
        && 32'(in.vertex_prob) > 32'(PROB_MIN)
        && 32'(in.dca) < 32'(DCA_MAX)
        && 32'(in.chi2) < 32'(CHI2_MAX);
    assign loose_in  = in.dau_mass > loose_low_reg && in.dau_mass < loose_high_reg;
    assign tight_in  = in.dau_mass > tight_low_reg && in.dau_mass < tight_high_reg;
    assign tight_out = in.dau_mass < tight_low_reg || in.dau_mass > tight_high_reg;

    assign diff = mass_reg - mdau_reg;
    assign rh = in.read_address[14:12];
    assign rp = in.read_address[11:9];
    assign rb = in.read_address[8:0];

    // fill bits: 0 dau, 1 sig, 2 sigdiff, 3 sig (type 2), 4 bkg, 5 bkgdiff
    always_comb
    begin
        case (fidx_reg)
            3'd0: fill_hist = H_DAU;
            3'd1: fill_hist = H_SIG;
            3'd2: fill_hist = H_SIGDIFF;
            3'd3: fill_hist = H_SIG;
            3'd4: fill_hist = H_BKG;
            3'd5: fill_hist = H_BKGDIFF;
            default: fill_hist = H_DAU;
        endcase
    end

    always_comb
    begin
        breq.start = state_reg == S_NEXT && fill_reg[fidx_reg];
        case (fidx_reg)
            3'd0:
            begin
                breq.x = mdau_reg; breq.lo = loose_low_reg; breq.hi = loose_high_reg;
            end
            3'd2, 3'd5:
            begin
                breq.x = diff; breq.lo = DIFF_LOW; breq.hi = DIFF_HIGH;
                if (mass_reg < mdau_reg)
                begin
                    breq.x = '0;
                end
            end
            default:
            begin
                breq.x = mass_reg; breq.lo = mass_low_reg; breq.hi = mass_high_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        ptb_next    = ptb_reg;
        fill_next   = fill_reg;
        fidx_next   = fidx_reg;
        addr_next   = addr_reg;
        rvalid_next = rvalid_reg;
        passed_next = passed_reg;
        optb_next   = optb_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
        ram_raddr   = addr_reg;
        in.ready    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in.ready = 1'b1;
                if (in.valid)
                begin
                    if (in.op)
                    begin
                        rvalid_next = 32'(rh) < HIST_COUNT && 32'(rp) < NUM_PT_BINS
                            && 32'(rb) < BPH;
                        addr_next = AW'((32'(rh) * NUM_PT_BINS + 32'(rp)) * BPH + 32'(rb));
                        passed_next = 1'b0;
                        optb_next   = '0;
                        state_next  = S_RREAD;
                    end
                    else
                    begin
                        ptb_next    = ptb_calc;
                        optb_next   = ptb_calc;
                        passed_next = pass_calc;
                        count_next  = '0;
                        fill_next   = pass_calc ? {2'b00, tight_out, tight_out,
                            type_sel_reg == TYPE_SIGNAL_ALL,
                            loose_in && tight_in, loose_in && tight_in, loose_in} : '0;
                        fidx_next   = '0;
                        state_next  = S_NEXT;
                    end
                end
            end
            S_NEXT:
            begin
                if (fidx_reg == 3'd6)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
                else if (fill_reg[fidx_reg])
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    fidx_next = fidx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (bdone)
                begin
                    addr_next = AW'((32'(fill_hist) * NUM_PT_BINS + 32'(ptb_reg)) * BPH
                        + 32'(bbin));
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                ram_we     = 1'b1;
                fidx_next  = fidx_reg + 1'b1;
                state_next = S_NEXT;
            end
            S_RREAD:
            begin
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                count_next  = rvalid_reg ? ram_rdata : '0;
                ovalid_next = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out.ready)
                begin
                    ovalid_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            ovalid_reg     <= 1'b0;
            fidx_reg       <= '0;
            fill_reg       <= '0;
            type_sel_reg   <= 3'd2;
            mass_low_reg   <= 24'd1782579;
            mass_high_reg  <= 24'd2202009;
            tight_low_reg  <= '0;
            tight_high_reg <= '1;
            loose_low_reg  <= '0;
            loose_high_reg <= '1;
            fsig_min_reg   <= 16'd512;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            fidx_reg   <= fidx_next;
            fill_reg   <= fill_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TYPE_SEL:   type_sel_reg   <= cfg_data[2:0];
                    REG_MASS_LOW:   mass_low_reg   <= cfg_data;
                    REG_MASS_HIGH:  mass_high_reg  <= cfg_data;
                    REG_TIGHT_LOW:  tight_low_reg  <= cfg_data;
                    REG_TIGHT_HIGH: tight_high_reg <= cfg_data;
                    REG_LOOSE_LOW:  loose_low_reg  <= cfg_data;
                    REG_LOOSE_HIGH: loose_high_reg <= cfg_data;
                    REG_FSIG_MIN:   fsig_min_reg   <= cfg_data[15:0];
                    default:        fsig_min_reg   <= fsig_min_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in.valid)
        begin
            mass_reg <= in.mass;
            mdau_reg <= in.dau_mass;
        end
        ptb_reg    <= ptb_next;
        addr_reg   <= addr_next;
        rvalid_reg <= rvalid_next;
        passed_reg <= passed_next;
        optb_reg   <= optb_next;
        count_reg  <= count_next;
    end

    assign out.valid     = ovalid_reg;
    assign out.passed    = passed_reg;
    assign out.pt_bin    = optb_reg;
    assign out.bin_count = count_reg;
endmodule
`default_nettype wire

[hdl/cch_ram.sv]
`default_nettype none
module cch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 14080
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hdl/cch_binner.sv]
`default_nettype none
// Restoring divider: bin = 1 + floor(N*(x-lo)/(hi-lo)), one quotient bit a cycle.
module cch_binner
    import cch_pkg::*;
#(
    parameter int NUM_MASS_BINS = 350
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bin_req_t req,
    output logic          done,
    output logic [$clog2(NUM_MASS_BINS+2)-1:0] bin
);
    localparam int BIN_W = $clog2(NUM_MASS_BINS + 2);
    localparam int QW    = $clog2(NUM_MASS_BINS + 1);
    localparam int NUM_W = MASS_W + QW;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [BIN_W-1:0] OVER = BIN_W'(NUM_MASS_BINS + 1);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [MASS_W:0]   rem_reg, rem_next;
    logic [MASS_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [MASS_W:0]   trial;
    logic [NUM_W-1:0]  scaled;

    assign scaled = NUM_W'(req.x - req.lo) * NUM_W'(NUM_MASS_BINS);
    assign trial  = {rem_reg[MASS_W-1:0], num_reg[NUM_W-1]};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        bin_next  = bin_reg;
        if (req.start)
        begin
            if (req.x < req.lo)
            begin
                bin_next  = '0;
                done_next = 1'b1;
            end
            else if (req.hi <= req.lo || req.x >= req.hi)
            begin
                bin_next  = OVER;
                done_next = 1'b1;
            end
            else
            begin
                num_next  = scaled;
                den_next  = req.hi - req.lo;
                rem_next  = '0;
                cnt_next  = STEP_W'(NUM_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next   = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                bin_next  = BIN_W'(num_next[QW-1:0]) + BIN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        bin_reg <= bin_next;
    end

    assign done = done_reg;
    assign bin  = bin_reg;
endmodule
`default_nettype wire

[hdl/cch_checker.sv]
`default_nettype none
module cch_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_passed,
    input wire logic [2:0]  out_pt_bin,
    input wire logic [31:0] out_bin_count
);
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");
    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
    a_read_passed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_passed) |-> out_bin_count == 32'd0)
        else $error("passing candidate with count");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_pt_bin))
        else $error("stalled result changed");
endmodule

bind candidate_cut_histogrammer_top cch_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .out_passed(out.passed),
    .out_pt_bin(out.pt_bin), .out_bin_count(out.bin_count));
`default_nettype wire

[sim/candidate_cut_histogrammer_top_test.sv]
`timescale 1ns / 1ps
module candidate_cut_histogrammer_top_test;
    import cch_pkg::*;

    localparam int PT_BINS   = 8;
    localparam int MASS_BINS = 350;
    localparam int ANGLE_LIM = 8192;
    localparam int PROB_LIM  = 3277;
    localparam int DCA_LIM   = 64;
    localparam int CHI2_LIM  = 512;
    localparam int BINS_PER  = MASS_BINS + 2;
    localparam int STORE_DEPTH = HIST_COUNT * PT_BINS * BINS_PER;
    localparam logic OP_CAND = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct {
        logic               op;
        logic [2:0]         cand_type;
        logic [23:0]        mass;
        logic [23:0]        dau_mass;
        logic [15:0]        pt;
        logic signed [15:0] eta;
        logic [15:0]        fsig;
        logic [15:0]        angle;
        logic [15:0]        prob;
        logic [15:0]        dca;
        logic [15:0]        chi2;
        logic [14:0]        addr;
    } cand_word_t;

    typedef struct {
        logic        passed;
        logic [2:0]  pt_bin;
        logic [31:0] bin_count;
    } result_word_t;

    typedef struct {
        cand_word_t   w;
        bit           typed;
        result_word_t r;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cch_in_if  in_if();
    cch_out_if out_if();

    candidate_cut_histogrammer_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in(in_if.sink),
        .out(out_if.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [31:0] hist_counts [0:STORE_DEPTH-1];
    logic [2:0]  sel_type;
    logic [23:0] win_lo, win_hi, tight_lo, tight_hi, loose_lo, loose_hi;
    logic [15:0] fsig_min;

    result_word_t expected_results[$];
    stim_row_t    dir_tab[$];
    int errors = 0;
    int n_cand = 0, n_pass = 0, n_read = 0, n_nonzero = 0;
    bit idle_in = 1, idle_out = 1, hold_out = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int mass_bin(longint x, longint lo, longint hi);
        if (x < lo)
            return 0;
        if (hi <= lo || x >= hi)
            return MASS_BINS + 1;
        return 1 + int'(((x - lo) * MASS_BINS) / (hi - lo));
    endfunction

    function automatic void bump(logic [2:0] h, int p, int b);
        int idx;
        idx = (int'(h) * PT_BINS + p) * BINS_PER + b;
        if (hist_counts[idx] != 32'hFFFF_FFFF)
            hist_counts[idx]++;
    endfunction

    function automatic result_word_t predict_word(cand_word_t w);
        result_word_t r;
        int h, p, b, ptb, mb;
        longint diff;
        bit ok;
        r = '{1'b0, 3'd0, 32'd0};
        if (w.op == OP_READ)
        begin
            h = w.addr[14:12];
            p = w.addr[11:9];
            b = w.addr[8:0];
            if (h < HIST_COUNT && p < PT_BINS && b < BINS_PER)
                r.bin_count = hist_counts[(h * PT_BINS + p) * BINS_PER + b];
            return r;
        end
        ptb = 7;
        for (int i = 0; i < 8; i++)
            if (w.pt >= PT_EDGES[i] && w.pt < PT_EDGES[i+1])
            begin
                ptb = i;
                break;
            end
        if (ptb > PT_BINS - 1)
            ptb = PT_BINS - 1;
        ok = w.cand_type == sel_type && w.eta <= ETA_LIMIT && w.eta >= -ETA_LIMIT
            && w.mass > win_lo && w.mass < win_hi && w.fsig > fsig_min
            && w.angle < ANGLE_LIM && w.prob > PROB_LIM && w.dca < DCA_LIM
            && w.chi2 < CHI2_LIM;
        if (ok)
        begin
            mb = mass_bin(w.mass, win_lo, win_hi);
            diff = longint'(w.mass) - longint'(w.dau_mass);
            if (w.dau_mass > loose_lo && w.dau_mass < loose_hi)
            begin
                bump(H_DAU, ptb, mass_bin(w.dau_mass, loose_lo, loose_hi));
                if (w.dau_mass > tight_lo && w.dau_mass < tight_hi)
                begin
                    bump(H_SIG, ptb, mb);
                    bump(H_SIGDIFF, ptb, mass_bin(diff, DIFF_LOW, DIFF_HIGH));
                end
            end
            if (sel_type == TYPE_SIGNAL_ALL)
                bump(H_SIG, ptb, mb);
            if (w.dau_mass < tight_lo || w.dau_mass > tight_hi)
            begin
                bump(H_BKG, ptb, mb);
                bump(H_BKGDIFF, ptb, mass_bin(diff, DIFF_LOW, DIFF_HIGH));
            end
        end
        r.passed = ok;
        r.pt_bin = ptb[2:0];
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_TYPE_SEL:   sel_type = data[2:0];
            REG_MASS_LOW:   win_lo = data;
            REG_MASS_HIGH:  win_hi = data;
            REG_TIGHT_LOW:  tight_lo = data;
            REG_TIGHT_HIGH: tight_hi = data;
            REG_LOOSE_LOW:  loose_lo = data;
            REG_LOOSE_HIGH: loose_hi = data;
            REG_FSIG_MIN:   fsig_min = data[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(input logic [2:0] t, input logic [23:0] ml, input logic [23:0] mh,
                            input logic [23:0] tl, input logic [23:0] th,
                            input logic [23:0] ll, input logic [23:0] lh,
                            input logic [15:0] fm);
        in_if.valid <= 1'b0;
        wait_idle();
        write_reg(REG_TYPE_SEL, {21'($urandom_range(0, 2097151)), t});
        write_reg(REG_MASS_LOW, ml);
        write_reg(REG_MASS_HIGH, mh);
        write_reg(REG_TIGHT_LOW, tl);
        write_reg(REG_TIGHT_HIGH, th);
        write_reg(REG_LOOSE_LOW, ll);
        write_reg(REG_LOOSE_HIGH, lh);
        write_reg(REG_FSIG_MIN, {8'($urandom_range(0, 255)), fm});
    endtask

    task automatic send_word(input cand_word_t w, input bit typed, input result_word_t want);
        int gap;
        result_word_t r;
        gap = idle_in ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.op             <= w.op;
        in_if.cand_type      <= w.cand_type;
        in_if.mass           <= w.mass;
        in_if.dau_mass       <= w.dau_mass;
        in_if.pt             <= w.pt;
        in_if.eta            <= w.eta;
        in_if.flight_sig     <= w.fsig;
        in_if.pointing_angle <= w.angle;
        in_if.vertex_prob    <= w.prob;
        in_if.dca            <= w.dca;
        in_if.chi2           <= w.chi2;
        in_if.read_address   <= w.addr;
        do
            @(posedge clk);
        while (!in_if.ready);
        r = predict_word(w);
        if (w.op == OP_READ)
        begin
            n_read++;
            if (r.bin_count != 0)
                n_nonzero++;
        end
        else
        begin
            n_cand++;
            if (r.passed)
                n_pass++;
        end
        expected_results.push_back(typed ? want : r);
    endtask

    function automatic cand_word_t good_cand();
        cand_word_t w;
        w.op        = OP_CAND;
        w.cand_type = sel_type;
        w.mass      = (win_hi > win_lo + 1) ? 24'($urandom_range(win_lo + 1, win_hi - 1))
                                            : 24'($urandom);
        case ($urandom_range(0, 3))
            0: w.dau_mass = w.mass - 24'($urandom_range(135000, 168000));
            1: w.dau_mass = (loose_hi > loose_lo + 1)
                   ? 24'($urandom_range(loose_lo + 1, loose_hi - 1)) : 24'($urandom);
            2: w.dau_mass = (tight_hi > tight_lo + 1)
                   ? 24'($urandom_range(tight_lo + 1, tight_hi - 1)) : 24'($urandom);
            default: w.dau_mass = 24'($urandom);
        endcase
        w.pt    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12000));
        w.eta   = 16'($signed($urandom_range(0, 16384)) - 8192);
        w.fsig  = (fsig_min < 16'hFFFF) ? 16'($urandom_range(fsig_min + 1, 65535)) : 16'hFFFF;
        w.angle = 16'($urandom_range(0, ANGLE_LIM - 1));
        w.prob  = 16'($urandom_range(PROB_LIM + 1, 65535));
        w.dca   = 16'($urandom_range(0, DCA_LIM - 1));
        w.chi2  = 16'($urandom_range(0, CHI2_LIM - 1));
        w.addr  = 15'($urandom);
        case ($urandom_range(0, 14))
            0: w.cand_type = 3'($urandom);
            1: w.eta = 16'($urandom);
            2: w.mass = 24'($urandom);
            3: w.fsig = 16'($urandom_range(0, fsig_min));
            4: w.angle = 16'($urandom_range(ANGLE_LIM, 65535));
            5: w.prob = 16'($urandom_range(0, PROB_LIM));
            6: w.dca = 16'($urandom_range(DCA_LIM, 65535));
            7: w.chi2 = 16'($urandom_range(CHI2_LIM, 65535));
            default: ;
        endcase
        return w;
    endfunction

    function automatic cand_word_t read_word(bit wild);
        cand_word_t w;
        w = good_cand();
        w.op = OP_READ;
        if (wild)
            w.addr = 15'($urandom);
        else
            w.addr = {3'($urandom_range(0, HIST_COUNT - 1)), 3'($urandom),
                      9'($urandom_range(0, BINS_PER - 1))};
        return w;
    endfunction

    function automatic void add_row(cand_word_t w, bit typed, logic p, logic [2:0] ptb,
                                    logic [31:0] cnt);
        stim_row_t s;
        s.w = w;
        s.typed = typed;
        s.r = '{p, ptb, cnt};
        dir_tab.push_back(s);
    endfunction

    always @(posedge clk)
        if (out_if.valid && out_if.ready)
        begin
            if (expected_results.size() == 0)
                report("unexpected word", out_if.bin_count, 0);
            else
            begin
                result_word_t e;
                e = expected_results.pop_front();
                if (out_if.passed !== e.passed)
                    report("passed", out_if.passed, e.passed);
                if (out_if.pt_bin !== e.pt_bin)
                    report("pt_bin", out_if.pt_bin, e.pt_bin);
                if (out_if.bin_count !== e.bin_count)
                    report("bin_count", out_if.bin_count, e.bin_count);
            end
        end

    initial
    begin
        int stall;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_out ? $urandom_range(0, 15) : 0;
            if (hold_out)
            begin
                stall = 400;
                hold_out = 0;
            end
            if (stall > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_if.valid);
        end
    end

    initial
    begin
        cand_word_t w;
        in_if.valid = 1'b0;
        in_if.op = OP_CAND;
        in_if.cand_type = '0;
        in_if.mass = '0;
        in_if.dau_mass = '0;
        in_if.pt = '0;
        in_if.eta = '0;
        in_if.flight_sig = '0;
        in_if.pointing_angle = '0;
        in_if.vertex_prob = '0;
        in_if.dca = '0;
        in_if.chi2 = '0;
        in_if.read_address = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            hist_counts[i] = '0;
        sel_type = 3'd2;
        win_lo = 24'd1782579;
        win_hi = 24'd2202009;
        tight_lo = 24'd0;
        tight_hi = 24'hFFFFFF;
        loose_lo = 24'd0;
        loose_hi = 24'hFFFFFF;
        fsig_min = 16'd512;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        w = read_word(0);
        w.addr = {H_DAU, 3'd0, 9'd0};
        add_row(w, 1, 0, 0, 0);
        w.addr = {H_BKGDIFF, 3'd7, 9'd351};
        add_row(w, 1, 0, 0, 0);
        w.addr = {3'd5, 3'd0, 9'd1};
        add_row(w, 1, 0, 0, 0);
        w.addr = 15'h7FFF;
        add_row(w, 1, 0, 0, 0);
        w.addr = {H_SIG, 3'd3, 9'd352};
        add_row(w, 1, 0, 0, 0);
        w = good_cand();
        w.cand_type = 3'd2; w.mass = 24'd2000000; w.dau_mass = 24'd1850000;
        w.eta = 16'sd8192; w.fsig = 16'd513; w.angle = 16'd8191; w.prob = 16'd3278;
        w.dca = 16'd63; w.chi2 = 16'd511; w.pt = 16'd0;
        add_row(w, 1, 1, 0, 0);
        w.eta = -16'sd8192; w.pt = 16'd1023;
        add_row(w, 1, 1, 0, 0);
        w.pt = 16'd1024; w.dau_mass = 24'd2100000;
        add_row(w, 1, 1, 1, 0);
        w.pt = 16'd51199; w.mass = 24'd1782580; w.dau_mass = 24'd0;
        add_row(w, 1, 1, 7, 0);
        w.pt = 16'd51200; w.mass = 24'd2202008; w.dau_mass = 24'hFFFFFF;
        add_row(w, 1, 1, 7, 0);
        w.pt = 16'hFFFF;
        add_row(w, 1, 1, 7, 0);
        w.pt = 16'd6400; w.eta = 16'sd8193;
        add_row(w, 1, 0, 6, 0);
        w.eta = 16'sh8000;
        add_row(w, 1, 0, 6, 0);
        w.eta = 16'sd0; w.mass = 24'd1782579;
        add_row(w, 1, 0, 6, 0);
        w.mass = 24'd2202009;
        add_row(w, 1, 0, 6, 0);
        w.mass = 24'd1900000; w.fsig = 16'd512;
        add_row(w, 1, 0, 6, 0);
        w.fsig = 16'hFFFF; w.angle = 16'd8192;
        add_row(w, 1, 0, 6, 0);
        w.angle = 16'd0; w.prob = 16'd3277;
        add_row(w, 1, 0, 6, 0);
        w.prob = 16'hFFFF; w.dca = 16'd64;
        add_row(w, 1, 0, 6, 0);
        w.dca = 16'd0; w.chi2 = 16'd512;
        add_row(w, 1, 0, 6, 0);
        w.chi2 = 16'd0; w.cand_type = 3'd7;
        add_row(w, 1, 0, 6, 0);
        w.cand_type = 3'd2; w.dau_mass = 24'd1800000;
        add_row(w, 0, 0, 0, 0);
        w = read_word(0);
        w.addr = {H_SIG, 3'd6, 9'd0};
        for (int b = 100; b < 104; b++)
        begin
            w.addr[8:0] = 9'(b);
            add_row(w, 0, 0, 0, 0);
        end
        foreach (dir_tab[i])
            send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: ;
                1: set_regs(3'd3, 24'h100000, 24'h300000, 24'h180000, 24'h200000,
                            24'h080000, 24'h400000, 16'd0);
                2: set_regs(3'd2, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                            24'h000000, 24'hFFFFFF, 16'd0);
                3: set_regs(3'd5, 24'h200000, 24'h200001, 24'h300000, 24'h100000,
                            24'h300000, 24'h100000, 16'hFFFE);
                4: set_regs(3'd1, 24'h1B3333, 24'h1B3333, 24'h1C0000, 24'h1D0000,
                            24'h1C0000, 24'h1C0000, 16'd300);
                default: set_regs(3'd0, 24'h000001, 24'h00F000, 24'h001000, 24'h008000,
                                  24'h000800, 24'h00C000, 16'd1);
            endcase
            idle_in = ph != 2;
            idle_out = ph != 4;
            for (int n = 0; n < 155; n++)
            begin
                if (ph == 1 && n == 60)
                    hold_out = 1;
                case ($urandom_range(0, 9))
                    0, 1: send_word(read_word($urandom_range(0, 4) == 0), 0, '{0, 0, 0});
                    2: send_word(read_word(1), 0, '{0, 0, 0});
                    default: send_word(good_cand(), 0, '{0, 0, 0});
                endcase
            end
        end
        @(posedge clk);
        in_if.valid <= 1'b0;
        wait_idle();
        repeat (300) @(posedge clk);
        $display("covered %0d candidates (%0d passing) and %0d bin reads (%0d nonzero)",
                 n_cand, n_pass, n_read, n_nonzero);
        $display("six register settings, extremes and empty windows included; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
